/* rtl/aapu_pkg.sv */
// ----------------------------------------------------------------------------
// aapu_pkg
// Shared types and fixed-point constants of the arctangent / atan2 unit.
// ----------------------------------------------------------------------------
package aapu_pkg;

   // fraction bits of the input values and of the result angle
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 32;
   localparam int ANGLE_W   = FRAC_BITS + 3;

   // width of a magnitude widened to q30
   localparam int AW        = IN_W + 30 - FRAC_BITS;

   // operation codes
   localparam logic MODE_ATAN  = 1'b0;
   localparam logic MODE_ATAN2 = 1'b1;

   // q30 constants
   localparam logic [33:0]        Q30_ONE     = 34'd1073741824;
   localparam logic [33:0]        K_TAN3PI8   = 34'd2592242071;
   localparam logic [33:0]        K_TANPI8    = 34'd444758423;
   localparam logic signed [33:0] K_HALFPI    = 34'sd1686629706;
   localparam logic signed [33:0] K_QUARTERPI = 34'sd843314853;
   localparam logic signed [33:0] K_PI        = 34'sd3373259422;
   localparam logic signed [33:0] K_C1        = -34'sd357911919;
   localparam logic signed [33:0] K_C2        = 34'sd214679108;
   localparam logic signed [33:0] K_C3        = -34'sd152566891;
   localparam logic [31:0]        K_C4        = 32'd114420753;

   typedef struct packed {
      logic                   mode;
      logic signed [IN_W-1:0] y_value;
      logic signed [IN_W-1:0] x_value;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic                      ratio_saturated;
   } rsp_type;

endpackage

/* rtl/atan_atan2_poly_unit.sv */
// ----------------------------------------------------------------------------
// atan_atan2_poly_unit
// Pipelined fixed-point atan(x) and atan2(y, x) with minimax polynomial.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns
// one angle per request, in order. Between acceptance and result lie two
// bit-serial dividers laid out as pipeline stages (the y/x ratio divider,
// two quotient bits per stage over 16 stages, and the range reduction
// divider, two bits per stage over 15 stages) followed by the polynomial
// chain of registered 32x32 multipliers. A stall on the result side
// freezes the whole pipeline; nothing is dropped or repeated.
// mode 0 returns atan(x_value) and ignores y_value; mode 1 returns
// atan2(y_value, x_value) with a zero abscissa giving +-pi/2 or 0 and an
// out-of-range ratio clamped and flagged in ratio_saturated. Inputs are
// signed q16.16, the angle is signed q3.16 in radians.
module atan_atan2_poly_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aapu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aapu_pkg::rsp_type rsp_data
);

   localparam int FB        = aapu_pkg::FRAC_BITS;
   localparam int AW        = aapu_pkg::AW;
   localparam int NW        = 61;
   localparam int RD_STEPS  = 2;
   localparam int RD_STAGES = 32 / RD_STEPS;
   localparam int AD_BITS   = 30;
   localparam int AD_STEPS  = 2;
   localparam int AD_STAGES = AD_BITS / AD_STEPS;
   localparam int PL_N      = 13;
   localparam int STG_N     = (RD_STAGES + 1) + 1 + (AD_STAGES + 1) + PL_N + 1;
   localparam int V_RD_END  = RD_STAGES;
   localparam int V_PL_LAST = STG_N - 2;

   // range reduction codes
   localparam logic [1:0] BIAS_NONE    = 2'd0;
   localparam logic [1:0] BIAS_QUARTER = 2'd1;
   localparam logic [1:0] BIAS_HALF    = 2'd2;

   localparam logic signed [aapu_pkg::ANGLE_W-1:0] ANGLE_PI =
      aapu_pkg::ANGLE_W'((aapu_pkg::K_PI + (34'sd1 <<< (29 - FB))) >>> (30 - FB));

   typedef struct packed {
      logic       mode;
      logic       zero_x;
      logic       ysign;
      logic       yzero;
      logic       xsign;
      logic       sat;
      logic       neg;
      logic [1:0] bias;
   } side_type;

   // ratio divider stage
   typedef struct packed {
      side_type    side;
      logic        big;
      logic        qneg;
      logic [31:0] ax;
      logic [31:0] rem;
      logic [31:0] dvd;
      logic [31:0] quo;
   } rd_type;

   // classified argument
   typedef struct packed {
      side_type      side;
      logic [AW-1:0] a;
   } a0_type;

   // reduction divider stage
   typedef struct packed {
      side_type             side;
      logic                 bypass;
      logic                 tneg;
      logic [29:0]          tsmall;
      logic [AW-1:0]        dsr;
      logic [AW-1:0]        rem;
      logic [AD_BITS-1:0]   dvd;
      logic [AD_BITS-1:0]   quo;
   } ad_type;

   // polynomial stage
   typedef struct packed {
      side_type           side;
      logic signed [31:0] t;
      logic signed [31:0] t2;
      logic signed [31:0] tt2;
      logic signed [31:0] p;
      logic [63:0]        prod_a;
      logic [63:0]        prod_b;
      logic               sign_a;
      logic               sign_b;
      logic signed [33:0] ang;
   } pl_type;

   logic                  advance;
   logic [STG_N-1:0]      vld_ff;
   logic [STG_N-1:0]      vld_in;
   rd_type                rd_ff [0:RD_STAGES];
   rd_type                rd_in [0:RD_STAGES];
   a0_type                a0_ff;
   a0_type                a0_in;
   ad_type                ad_ff [0:AD_STAGES];
   ad_type                ad_in [0:AD_STAGES];
   pl_type                pl_ff [0:PL_N-1];
   pl_type                pl_in [0:PL_N-1];
   aapu_pkg::rsp_type     rsp_ff;
   aapu_pkg::rsp_type     rsp_in;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? (32'd0 - 32'(v)) : 32'(v);
   endfunction

   // q30 product magnitude to signed value, rounded half away from zero
   function automatic logic signed [33:0] rnd30(input logic [63:0] m, input logic s);
      logic [63:0]        r;
      logic signed [33:0] v;
      r = (m + 64'd536870912) >> 30;
      v = signed'(r[33:0]);
      rnd30 = s ? -v : v;
   endfunction

   function automatic rd_type rd_step(input rd_type s);
      rd_type      r;
      logic [32:0] r2;
      r  = s;
      r2 = {r.rem, r.dvd[31]};
      r.dvd = r.dvd << 1;
      if (r2 >= {1'b0, r.ax}) begin
         r2    = r2 - {1'b0, r.ax};
         r.quo = {r.quo[30:0], 1'b1};
      end else begin
         r.quo = {r.quo[30:0], 1'b0};
      end
      r.rem = r2[31:0];
      rd_step = r;
   endfunction

   function automatic ad_type ad_step(input ad_type s);
      ad_type      r;
      logic [AW:0] r2;
      r  = s;
      r2 = {r.rem, r.dvd[AD_BITS-1]};
      r.dvd = r.dvd << 1;
      if (r2 >= {1'b0, r.dsr}) begin
         r2    = r2 - {1'b0, r.dsr};
         r.quo = {r.quo[AD_BITS-2:0], 1'b1};
      end else begin
         r.quo = {r.quo[AD_BITS-2:0], 1'b0};
      end
      r.rem = r2[AW-1:0];
      ad_step = r;
   endfunction

   // whole pipeline moves together; the output register frees the front
   assign advance   = !vld_ff[STG_N-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[STG_N-1];
   assign rsp_data  = rsp_ff;
   assign vld_in    = {vld_ff[STG_N-2:0], req_valid};

   // front stage and ratio divider
   always_comb begin
      rd_type      tmp;
      logic [31:0] yu;
      logic [31:0] xu;
      logic [31:0] ay;
      logic [31:0] ax;
      yu = req_data.y_value;
      xu = req_data.x_value;
      ay = yu[31] ? (32'd0 - yu) : yu;
      ax = xu[31] ? (32'd0 - xu) : xu;
      rd_in[0]             = '0;
      rd_in[0].side.mode   = req_data.mode;
      rd_in[0].side.zero_x = (xu == 32'd0);
      rd_in[0].side.ysign  = yu[31];
      rd_in[0].side.yzero  = (yu == 32'd0);
      rd_in[0].side.xsign  = xu[31];
      rd_in[0].qneg        = yu[31] ^ xu[31];
      // quotient would need more than 32 bits
      rd_in[0].big         = {32'd0, ay} >= ({32'd0, ax} << (32 - FB));
      rd_in[0].ax          = ax;
      rd_in[0].rem         = ay >> (32 - FB);
      rd_in[0].dvd         = ay << FB;
      for (int i = 1; i <= RD_STAGES; i++) begin
         tmp = rd_ff[i-1];
         for (int j = 0; j < RD_STEPS; j++) begin
            tmp = rd_step(tmp);
         end
         rd_in[i] = tmp;
      end
   end

   // clamp the ratio, widen to q30 and pick the reduction
   always_comb begin
      rd_type      s;
      logic [31:0] m;
      s = rd_ff[RD_STAGES];
      a0_in.side = s.side;
      if (s.side.mode == aapu_pkg::MODE_ATAN) begin
         m              = s.ax;
         a0_in.side.neg = s.side.xsign;
         a0_in.side.sat = 1'b0;
      end else if (!s.qneg) begin
         if (s.big || (s.quo > 32'h7FFF_FFFF)) begin
            m              = 32'h7FFF_FFFF;
            a0_in.side.sat = !s.side.zero_x;
         end else begin
            m              = s.quo;
            a0_in.side.sat = 1'b0;
         end
         a0_in.side.neg = 1'b0;
      end else begin
         if (s.big || (s.quo > 32'h8000_0000)) begin
            m              = 32'h8000_0000;
            a0_in.side.sat = !s.side.zero_x;
         end else begin
            m              = s.quo;
            a0_in.side.sat = 1'b0;
         end
         a0_in.side.neg = 1'b1;
      end
      a0_in.a = AW'(m) << (30 - FB);
      priority if (a0_in.a > AW'(aapu_pkg::K_TAN3PI8)) begin
         a0_in.side.bias = BIAS_HALF;
      end else if (a0_in.a > AW'(aapu_pkg::K_TANPI8)) begin
         a0_in.side.bias = BIAS_QUARTER;
      end else begin
         a0_in.side.bias = BIAS_NONE;
      end
   end

   // set up the reduction division and run it
   always_comb begin
      ad_type        tmp;
      logic [NW-1:0] num;
      logic [AW-1:0] den;
      ad_in[0]        = '0;
      ad_in[0].side   = a0_ff.side;
      ad_in[0].tsmall = a0_ff.a[29:0];
      ad_in[0].bypass = (a0_ff.side.bias == BIAS_NONE);
      unique case (a0_ff.side.bias)
         BIAS_HALF: begin
            // -1/a
            den = a0_ff.a;
            num = (NW'(1) << 60) + NW'(a0_ff.a >> 1);
            ad_in[0].tneg = 1'b1;
         end
         BIAS_QUARTER: begin
            // (a-1)/(a+1)
            den = a0_ff.a + AW'(aapu_pkg::Q30_ONE);
            if (a0_ff.a >= AW'(aapu_pkg::Q30_ONE)) begin
               num = (NW'(a0_ff.a - AW'(aapu_pkg::Q30_ONE)) << 30) + NW'(den >> 1);
               ad_in[0].tneg = 1'b0;
            end else begin
               num = (NW'(AW'(aapu_pkg::Q30_ONE) - a0_ff.a) << 30) + NW'(den >> 1);
               ad_in[0].tneg = 1'b1;
            end
         end
         default: begin
            den = AW'(1);
            num = '0;
            ad_in[0].tneg = 1'b0;
         end
      endcase
      ad_in[0].dsr = den;
      ad_in[0].rem = AW'(num >> AD_BITS);
      ad_in[0].dvd = num[AD_BITS-1:0];
      for (int i = 1; i <= AD_STAGES; i++) begin
         tmp = ad_ff[i-1];
         for (int j = 0; j < AD_STEPS; j++) begin
            tmp = ad_step(tmp);
         end
         ad_in[i] = tmp;
      end
   end

   // polynomial chain, each multiply stage followed by a rounding stage
   always_comb begin
      ad_type             d;
      logic signed [31:0] q;
      logic signed [33:0] r;
      logic signed [33:0] r2;
      logic signed [33:0] bv;
      d = ad_ff[AD_STAGES];
      q = signed'({2'b00, d.quo});
      pl_in[0]      = '0;
      pl_in[0].side = d.side;
      pl_in[0].t    = d.bypass ? signed'({2'b00, d.tsmall}) : (d.tneg ? -q : q);

      for (int k = 1; k < PL_N; k++) begin
         pl_in[k] = pl_ff[k-1];
      end

      // t squared
      pl_in[1].prod_a = mag32(pl_ff[0].t) * mag32(pl_ff[0].t);
      pl_in[1].sign_a = 1'b0;
      r = rnd30(pl_ff[1].prod_a, pl_ff[1].sign_a);
      pl_in[2].t2 = r[31:0];
      // t2*c4 and t*t2 side by side
      pl_in[3].prod_a = mag32(pl_ff[2].t2) * aapu_pkg::K_C4;
      pl_in[3].sign_a = 1'b0;
      pl_in[3].prod_b = mag32(pl_ff[2].t) * mag32(pl_ff[2].t2);
      pl_in[3].sign_b = pl_ff[2].t[31] ^ pl_ff[2].t2[31];
      r  = aapu_pkg::K_C3 + rnd30(pl_ff[3].prod_a, pl_ff[3].sign_a);
      r2 = rnd30(pl_ff[3].prod_b, pl_ff[3].sign_b);
      pl_in[4].p   = r[31:0];
      pl_in[4].tt2 = r2[31:0];
      pl_in[5].prod_a = mag32(pl_ff[4].t2) * mag32(pl_ff[4].p);
      pl_in[5].sign_a = pl_ff[4].t2[31] ^ pl_ff[4].p[31];
      r = aapu_pkg::K_C2 + rnd30(pl_ff[5].prod_a, pl_ff[5].sign_a);
      pl_in[6].p = r[31:0];
      pl_in[7].prod_a = mag32(pl_ff[6].t2) * mag32(pl_ff[6].p);
      pl_in[7].sign_a = pl_ff[6].t2[31] ^ pl_ff[6].p[31];
      r = aapu_pkg::K_C1 + rnd30(pl_ff[7].prod_a, pl_ff[7].sign_a);
      pl_in[8].p = r[31:0];
      pl_in[9].prod_a = mag32(pl_ff[8].tt2) * mag32(pl_ff[8].p);
      pl_in[9].sign_a = pl_ff[8].tt2[31] ^ pl_ff[8].p[31];

      // bias + t + t^3 * p
      unique case (pl_ff[9].side.bias)
         BIAS_HALF:    bv = aapu_pkg::K_HALFPI;
         BIAS_QUARTER: bv = aapu_pkg::K_QUARTERPI;
         default:      bv = '0;
      endcase
      pl_in[10].ang = bv + 34'(pl_ff[9].t) + rnd30(pl_ff[9].prod_a, pl_ff[9].sign_a);

      // unfold the sign, or the zero abscissa answer
      if ((pl_ff[10].side.mode == aapu_pkg::MODE_ATAN2) && pl_ff[10].side.zero_x) begin
         if (pl_ff[10].side.yzero) begin
            pl_in[11].ang = '0;
         end else if (pl_ff[10].side.ysign) begin
            pl_in[11].ang = -aapu_pkg::K_HALFPI;
         end else begin
            pl_in[11].ang = aapu_pkg::K_HALFPI;
         end
      end else begin
         pl_in[11].ang = pl_ff[10].side.neg ? -pl_ff[10].ang : pl_ff[10].ang;
      end

      // left half plane moves by pi
      if ((pl_ff[11].side.mode == aapu_pkg::MODE_ATAN2) && !pl_ff[11].side.zero_x
          && pl_ff[11].side.xsign) begin
         pl_in[12].ang = pl_ff[11].side.ysign ? (pl_ff[11].ang - aapu_pkg::K_PI)
                                              : (pl_ff[11].ang + aapu_pkg::K_PI);
      end else begin
         pl_in[12].ang = pl_ff[11].ang;
      end
   end

   // q30 to output format, rounded half away from zero
   always_comb begin
      logic [33:0]                  am;
      logic [33:0]                  rm;
      logic [aapu_pkg::ANGLE_W-1:0] v;
      am = pl_ff[PL_N-1].ang[33] ? (34'd0 - 34'(pl_ff[PL_N-1].ang))
                                 : 34'(pl_ff[PL_N-1].ang);
      rm = (am + (34'd1 << (29 - FB))) >> (30 - FB);
      v  = rm[aapu_pkg::ANGLE_W-1:0];
      rsp_in.angle           = pl_ff[PL_N-1].ang[33] ? -v : v;
      rsp_in.ratio_saturated = pl_ff[PL_N-1].side.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff  <= rd_in;
         a0_ff  <= a0_in;
         ad_ff  <= ad_in;
         pl_ff  <= pl_in;
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // a frozen pipeline keeps every request in place
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (vld_ff == $past(vld_ff)))
      else $error("pipeline valid bits moved during a stall");

   // an in-range ratio leaves a proper remainder
   a_ratio_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[V_RD_END] && (rd_ff[RD_STAGES].side.mode == aapu_pkg::MODE_ATAN2)
       && !rd_ff[RD_STAGES].side.zero_x && !rd_ff[RD_STAGES].big)
      |-> (rd_ff[RD_STAGES].rem < rd_ff[RD_STAGES].ax))
      else $error("ratio divider remainder not below divisor");

   // single-argument requests never report a clamped ratio
   a_atan_nosat: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[V_PL_LAST] && advance && (pl_ff[PL_N-1].side.mode == aapu_pkg::MODE_ATAN))
      |=> !rsp_data.ratio_saturated)
      else $error("saturation flagged in single-argument mode");

   // the angle stays within minus pi to pi
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.angle <= ANGLE_PI) && (rsp_data.angle >= -ANGLE_PI)))
      else $error("angle outside minus pi to pi");
`endif

endmodule

/* tb/sv/aapu_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aapu_checker
// Watches both channels of the arctangent unit, predicts every angle and
// compares the results in order.
// ----------------------------------------------------------------------------
module aapu_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  aapu_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  aapu_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count,
   output int                sat_count
);

   localparam longint ONE30   = 64'sd1073741824;
   localparam longint TAN3PI8 = 64'sd2592242071;
   localparam longint TANPI8  = 64'sd444758423;
   localparam longint HALFPI  = 64'sd1686629706;
   localparam longint QTRPI   = 64'sd843314853;
   localparam longint PI30    = 64'sd3373259422;
   localparam longint C1      = -64'sd357911919;
   localparam longint C2      = 64'sd214679108;
   localparam longint C3      = -64'sd152566891;
   localparam longint C4      = 64'sd114420753;

   aapu_pkg::rsp_type angle_queue[$];

   function automatic longint unsigned mag(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   // q30 product, halves away from zero
   function automatic longint qmul(longint a, longint b);
      longint unsigned p;
      p = (mag(a) * mag(b) + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
      return (n + d / 2) / d;
   endfunction

   function automatic longint atan_fixed(longint v);
      longint unsigned a;
      longint t, bias, t2, p, r;
      a = mag(v) << (30 - aapu_pkg::FRAC_BITS);
      bias = 0;
      if (a > TAN3PI8) begin
         t = -longint'(rdiv(64'd1 << 60, a));
         bias = HALFPI;
      end else if (a > TANPI8) begin
         if (a >= ONE30) t = rdiv((a - ONE30) << 30, a + ONE30);
         else t = -longint'(rdiv((ONE30 - a) << 30, a + ONE30));
         bias = QTRPI;
      end else begin
         t = a;
      end
      t2 = qmul(t, t);
      p = C3 + qmul(t2, C4);
      p = C2 + qmul(t2, p);
      p = C1 + qmul(t2, p);
      r = bias + t + qmul(qmul(t, t2), p);
      return v < 0 ? -r : r;
   endfunction

   function automatic aapu_pkg::rsp_type predict_angle(aapu_pkg::req_type rq);
      aapu_pkg::rsp_type rs;
      longint y, x, ang, ratio;
      longint unsigned q, m;
      logic qneg;
      y = rq.y_value;
      x = rq.x_value;
      rs.ratio_saturated = 1'b0;
      if (rq.mode == aapu_pkg::MODE_ATAN) begin
         ang = atan_fixed(x);
      end else if (x == 0) begin
         ang = y > 0 ? HALFPI : (y < 0 ? -HALFPI : 0);
      end else begin
         qneg = (y < 0) != (x < 0);
         q = (mag(y) << aapu_pkg::FRAC_BITS) / mag(x);
         if (!qneg && q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            rs.ratio_saturated = 1'b1;
         end else if (qneg && q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            rs.ratio_saturated = 1'b1;
         end
         ratio = qneg ? -longint'(q) : longint'(q);
         ang = atan_fixed(ratio);
         if (x < 0) ang += (y >= 0) ? PI30 : -PI30;
      end
      m = (mag(ang) + (64'd1 << (29 - aapu_pkg::FRAC_BITS))) >> (30 - aapu_pkg::FRAC_BITS);
      rs.angle = aapu_pkg::ANGLE_W'(ang < 0 ? -longint'(m) : longint'(m));
      return rs;
   endfunction

   always @(posedge clock) begin
      aapu_pkg::rsp_type want;
      if (reset) begin
         fail_count <= 0;
         sat_count  <= 0;
         angle_queue.delete();
      end else begin
         if (req_valid && req_ready) angle_queue.push_back(predict_angle(req_data));
         if (rsp_valid && rsp_ready) begin
            if (rsp_data.ratio_saturated) sat_count <= sat_count + 1;
            if (angle_queue.size() == 0) begin
               $display("%0t: unexpected result angle=%0d sat=%0b", $time,
                        rsp_data.angle, rsp_data.ratio_saturated);
               fail_count <= fail_count + 1;
            end else begin
               want = angle_queue.pop_front();
               if (want.angle !== rsp_data.angle) begin
                  $display("%0t: angle mismatch expected %0d actual %0d", $time,
                           want.angle, rsp_data.angle);
                  fail_count <= fail_count + 1;
               end else if (want.ratio_saturated !== rsp_data.ratio_saturated) begin
                  $display("%0t: saturation flag mismatch expected %0b actual %0b",
                           $time, want.ratio_saturated, rsp_data.ratio_saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = angle_queue.size();

endmodule

/* tb/sv/tb_atan_atan2_poly_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_atan_atan2_poly_unit
// Drives directed and random requests with random idle gaps on both sides;
// the checker predicts each angle and compares results in order.
// ----------------------------------------------------------------------------
module tb_atan_atan2_poly_unit;

   localparam int N_RANDOM  = 1500;
   localparam int LATENCY   = 48;
   localparam int MAX_CYCLE = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   aapu_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   aapu_pkg::rsp_type rsp_data;
   int                fail_count, pending_count, sat_count;
   int                cycle_count = 0;
   int                request_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   atan_atan2_poly_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   aapu_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count), .sat_count(sat_count)
   );

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("** atan_atan2_poly_unit: FAILED **");
         $finish;
      end
   end

   // receiver: random stall per result, with calm stretches
   always @(posedge clock) begin
      int stall;
      if (!reset) begin
         if (rsp_valid && rsp_ready || !rsp_ready) begin
            stall = ((cycle_count / 2000) % 3 == 0) ? 0 : $urandom_range(0, 7);
            if (stall == 0) rsp_ready <= 1'b1;
            else begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // one request; valid stays high across back-to-back requests
   task automatic send_request(input logic mode, input logic [31:0] y, input logic [31:0] x);
      int gap;
      gap = ((request_count / 300) % 3 == 1) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.mode    <= mode;
      req_data.y_value <= y;
      req_data.x_value <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      request_count++;
   endtask

   function automatic logic [31:0] random_value();
      unique case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
         2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
         3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
         4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'h8000_0000 + $urandom_range(0, 3);
         default: return 32'($signed($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   initial begin
      logic [31:0] edges [8];
      logic [31:0] yv, xv;
      edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF,
                32'h0001_0000, 32'hFFFF_0000, 32'h0000_6A0A};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero abscissa, reduction boundaries, saturation
      foreach (edges[i]) send_request(aapu_pkg::MODE_ATAN, 32'h5A5A_5A5A, edges[i]);
      send_request(aapu_pkg::MODE_ATAN, 32'h0, 32'h0002_6A0A);   // near tan(3pi/8)
      send_request(aapu_pkg::MODE_ATAN2, 32'h0001_0000, 32'h0);
      send_request(aapu_pkg::MODE_ATAN2, 32'hFFFF_0000, 32'h0);
      send_request(aapu_pkg::MODE_ATAN2, 32'h0, 32'h0);
      send_request(aapu_pkg::MODE_ATAN2, 32'h0, 32'hFFFF_0000);   // +pi on negative axis
      send_request(aapu_pkg::MODE_ATAN2, 32'h7FFF_FFFF, 32'h1);
      send_request(aapu_pkg::MODE_ATAN2, 32'h8000_0000, 32'h1);
      send_request(aapu_pkg::MODE_ATAN2, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(aapu_pkg::MODE_ATAN2, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(aapu_pkg::MODE_ATAN2, 32'h8000_0000, 32'h8000_0000);
      send_request(aapu_pkg::MODE_ATAN2, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(aapu_pkg::MODE_ATAN2, 32'hFFFF_FFFF, 32'h7FFF_FFFF);

      // drain completely once before the random part
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         yv = random_value();
         xv = ($urandom_range(0, 15) == 0) ? 32'h0 : random_value();
         send_request(logic'($urandom_range(0, 3) != 0), yv, xv);
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d requests sent in both modes, %0d results flagged as saturated",
               request_count, sat_count);
      if (fail_count == 0 && pending_count == 0)
         $display("** atan_atan2_poly_unit: PASSED **");
      else
         $display("** atan_atan2_poly_unit: FAILED **");
      $finish;
   end

endmodule
